[design/chm_pkg.sv]
`default_nettype none
package chm_pkg;

    // Table geometry
    localparam int SLOTS      = 1024;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int FULL_LIMIT = SLOTS * 7;
    localparam int LOAD_W     = CNT_W + 4;

    // Mixer constants
    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam int MIX_SH0 = 30;
    localparam int MIX_SH1 = 27;
    localparam int MIX_SH2 = 31;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // Stream widths
    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 56;

    typedef enum logic [1:0] {
        ACT_GET    = 2'd0,
        ACT_PUT    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_ITER   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_END       = 2'd3
    } status_t;

    typedef struct packed {
        action_t            action;
        logic [63:0]        key;
        logic [31:0]        handle;
        logic [CNT_W-1:0]   start;
        logic [SLOT_W-1:0]  home;
    } item_t;

    typedef struct packed {
        logic               valid;
        logic [SLOT_W-1:0]  home;
        logic [31:0]        value;
        logic [63:0]        key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic               we;
        logic [SLOT_W-1:0]  waddr;
        entry_t             wdata;
        logic [SLOT_W-1:0]  raddr;
    } mem_req_t;

    typedef struct packed {
        logic               hit;
        logic [31:0]        value;
        logic [CNT_W-1:0]   nxt_slot;
        status_t            status;
        logic [CNT_W-1:0]   total;
    } res_t;

endpackage
`default_nettype wire

[design/chm_ram.sv]
`default_nettype none
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[design/chm_front.sv]
`default_nettype none
module chm_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // key_x[31:0], key_z[63:32], value_handle[95:64], start_slot[106:96]
    input  wire logic [chm_pkg::S_DATA_W-1:0]      s_tdata,
    // action[1:0]
    input  wire logic [1:0]                        s_tuser,
    output logic                                   q_valid,
    output chm_pkg::item_t                         q_item,
    input  wire logic                              q_pop
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_HASH = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    localparam logic [2:0] STEP_LO1  = 3'd0;
    localparam logic [2:0] STEP_MID1 = 3'd1;
    localparam logic [2:0] STEP_HI1  = 3'd2;
    localparam logic [2:0] STEP_LO2  = 3'd3;
    localparam logic [2:0] STEP_MID2 = 3'd4;
    localparam logic [2:0] STEP_HI2  = 3'd5;

    fstate_t                 state_reg, state_next;
    logic [2:0]              step_reg, step_next;
    logic [63:0]             k_reg, k_next;
    logic [63:0]             acc_reg, acc_next;
    chm_pkg::item_t          item_reg, item_next;

    chm_pkg::item_t          fifo_reg [chm_pkg::Q_DEPTH];
    logic [chm_pkg::Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [chm_pkg::Q_CNT_W-1:0] fill_reg;

    logic [63:0] packed_key;
    logic [63:0] c_sel;
    logic [31:0] op_a, op_b;
    logic [63:0] prod, sum, mix1, mix2;
    logic        accept, push, fifo_full;

    assign s_tready   = (state_reg == F_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign fifo_full  = (fill_reg == chm_pkg::Q_CNT_W'(chm_pkg::Q_DEPTH));
    assign push       = (state_reg == F_PUSH) && !fifo_full;
    assign q_valid    = (fill_reg != '0);
    assign q_item     = fifo_reg[rd_ptr_reg];
    assign packed_key = {s_tdata[63:32], s_tdata[31:0]};

    // Shared 32x32 multiplier: one partial product per step
    always_comb
    begin
        c_sel = (step_reg < STEP_LO2) ? chm_pkg::MIX_C1 : chm_pkg::MIX_C2;
        op_a  = (step_reg == STEP_HI1 || step_reg == STEP_HI2) ? k_reg[63:32] : k_reg[31:0];
        op_b  = (step_reg == STEP_MID1 || step_reg == STEP_MID2) ? c_sel[63:32] : c_sel[31:0];
        prod  = 64'(op_a) * 64'(op_b);
        if (step_reg == STEP_LO1 || step_reg == STEP_LO2)
        begin
            sum = prod;
        end
        else
        begin
            sum = acc_reg + {prod[31:0], 32'd0};
        end
        mix1 = sum ^ (sum >> chm_pkg::MIX_SH1);
        mix2 = sum ^ (sum >> chm_pkg::MIX_SH2);
    end

    // Hash sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        item_next  = item_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    item_next.action = chm_pkg::action_t'(s_tuser);
                    item_next.key    = packed_key;
                    item_next.handle = s_tdata[95:64];
                    item_next.start  = s_tdata[106:96];
                    item_next.home   = '0;
                    k_next     = packed_key ^ (packed_key >> chm_pkg::MIX_SH0);
                    step_next  = STEP_LO1;
                    state_next = F_HASH;
                end
            end
            F_HASH:
            begin
                acc_next  = sum;
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_HI1)
                begin
                    k_next = mix1;
                end
                if (step_reg == STEP_HI2)
                begin
                    item_next.home = mix2[chm_pkg::SLOT_W-1:0];
                    state_next     = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!fifo_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        k_reg    <= k_next;
        acc_reg  <= acc_next;
        item_reg <= item_next;
    end

    // Hand-off queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !(q_pop && q_valid))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (!push && q_pop && q_valid)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item_reg;
        end
    end

endmodule
`default_nettype wire

[design/chm_back.sv]
`default_nettype none
module chm_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_valid,
    input  chm_pkg::item_t                         q_item,
    output logic                                   q_pop,
    output chm_pkg::mem_req_t                      mem_req,
    input  wire logic [chm_pkg::ENTRY_W-1:0]       mem_rdata,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output chm_pkg::res_t                          out_res
);

    typedef enum logic [9:0] {
        B_CLEAR = 10'b0000000001,
        B_IDLE  = 10'b0000000010,
        B_PRD   = 10'b0000000100,
        B_PEX   = 10'b0000001000,
        B_SRD   = 10'b0000010000,
        B_SEX   = 10'b0000100000,
        B_RRD   = 10'b0001000000,
        B_REX   = 10'b0010000000,
        B_ITRD  = 10'b0100000000,
        B_ITEX  = 10'b1000000000
    } bstate_t;

    localparam int SW = chm_pkg::SLOT_W;
    localparam int CW = chm_pkg::CNT_W;

    bstate_t                 state_reg, state_next;
    chm_pkg::item_t          item_reg, item_next;
    logic [SW-1:0]           addr_reg, addr_next;
    logic [SW-1:0]           probe_reg, probe_next;
    logic [SW-1:0]           nx_reg, nx_next;
    logic [CW-1:0]           shift_reg, shift_next;
    logic [CW-1:0]           iidx_reg, iidx_next;
    logic [SW-1:0]           clr_reg, clr_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [31:0]             held_reg, held_next;
    chm_pkg::entry_t         mov_reg, mov_next;
    chm_pkg::res_t           res_reg, res_next;
    logic                    out_valid_reg, out_valid_next;

    chm_pkg::entry_t         rd;
    chm_pkg::res_t           fin;
    logic                    finish;
    logic                    key_hit, load_full;
    logic [chm_pkg::LOAD_W-1:0] load10;

    assign rd        = chm_pkg::entry_t'(mem_rdata);
    assign key_hit   = rd.valid && (rd.key == item_reg.key);
    assign load10    = chm_pkg::LOAD_W'({count_reg, 3'b000}) + chm_pkg::LOAD_W'({count_reg, 1'b0});
    assign load_full = (load10 >= chm_pkg::LOAD_W'(chm_pkg::FULL_LIMIT));
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        addr_next      = addr_reg;
        probe_next     = probe_reg;
        nx_next        = nx_reg;
        shift_next     = shift_reg;
        iidx_next      = iidx_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        held_next      = held_reg;
        mov_next       = mov_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        q_pop          = 1'b0;
        finish         = 1'b0;
        fin            = '0;
        mem_req        = '0;
        mem_req.raddr  = addr_reg;
        mem_req.waddr  = addr_reg;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // Sweep valid marks to zero after reset
            B_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_reg;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == SW'(chm_pkg::SLOTS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    if (q_item.action == chm_pkg::ACT_ITER)
                    begin
                        if (q_item.start >= CW'(chm_pkg::SLOTS))
                        begin
                            finish       = 1'b1;
                            fin.nxt_slot = q_item.start;
                            fin.status   = chm_pkg::ST_END;
                        end
                        else
                        begin
                            iidx_next  = q_item.start;
                            addr_next  = q_item.start[SW-1:0];
                            state_next = B_ITRD;
                        end
                    end
                    else
                    begin
                        addr_next  = q_item.home;
                        probe_next = '0;
                        state_next = B_PRD;
                    end
                end
            end
            B_PRD:
            begin
                state_next = B_PEX;
            end
            // Examine one probe slot
            B_PEX:
            begin
                if (!rd.valid || (probe_reg == SW'(chm_pkg::SLOTS - 1) && !key_hit))
                begin
                    finish = 1'b1;
                    if (item_reg.action == chm_pkg::ACT_PUT)
                    begin
                        if (load_full || rd.valid)
                        begin
                            fin.status = chm_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_req.we          = 1'b1;
                            mem_req.wdata.valid = 1'b1;
                            mem_req.wdata.home  = item_reg.home;
                            mem_req.wdata.value = item_reg.handle;
                            mem_req.wdata.key   = item_reg.key;
                            count_next          = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        fin.status = chm_pkg::ST_NOT_FOUND;
                    end
                end
                else if (key_hit)
                begin
                    case (item_reg.action)
                        chm_pkg::ACT_PUT:
                        begin
                            finish              = 1'b1;
                            fin.hit             = 1'b1;
                            fin.value           = rd.value;
                            mem_req.we          = 1'b1;
                            mem_req.wdata       = rd;
                            mem_req.wdata.value = item_reg.handle;
                        end
                        chm_pkg::ACT_REMOVE:
                        begin
                            mem_req.we          = 1'b1;
                            mem_req.wdata       = rd;
                            mem_req.wdata.valid = 1'b0;
                            count_next          = count_reg - 1'b1;
                            held_next           = rd.value;
                            nx_next             = addr_reg + 1'b1;
                            addr_next           = addr_reg + 1'b1;
                            shift_next          = '0;
                            state_next          = B_SRD;
                        end
                        default:
                        begin
                            finish    = 1'b1;
                            fin.hit   = 1'b1;
                            fin.value = rd.value;
                        end
                    endcase
                end
                else
                begin
                    addr_next  = addr_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    state_next = B_PRD;
                end
            end
            B_SRD:
            begin
                state_next = B_SEX;
            end
            // Lift the next cluster entry out of its slot
            B_SEX:
            begin
                if (!rd.valid || shift_reg == CW'(chm_pkg::SLOTS))
                begin
                    finish    = 1'b1;
                    fin.hit   = 1'b1;
                    fin.value = held_reg;
                end
                else
                begin
                    mov_next            = rd;
                    mem_req.we          = 1'b1;
                    mem_req.waddr       = nx_reg;
                    mem_req.wdata       = rd;
                    mem_req.wdata.valid = 1'b0;
                    addr_next           = rd.home;
                    probe_next          = '0;
                    state_next          = B_RRD;
                end
            end
            B_RRD:
            begin
                state_next = B_REX;
            end
            // Find the first free slot for the lifted entry
            B_REX:
            begin
                if (!rd.valid || rd.key == mov_reg.key
                    || probe_reg == SW'(chm_pkg::SLOTS - 1))
                begin
                    mem_req.we          = 1'b1;
                    mem_req.wdata       = mov_reg;
                    mem_req.wdata.valid = 1'b1;
                    if (rd.valid && rd.key != mov_reg.key)
                    begin
                        mem_req.waddr = nx_reg;
                    end
                    nx_next    = nx_reg + 1'b1;
                    addr_next  = nx_reg + 1'b1;
                    shift_next = shift_reg + 1'b1;
                    state_next = B_SRD;
                end
                else
                begin
                    addr_next  = addr_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    state_next = B_RRD;
                end
            end
            B_ITRD:
            begin
                state_next = B_ITEX;
            end
            // Scan forward for an occupied slot
            B_ITEX:
            begin
                if (rd.valid)
                begin
                    finish       = 1'b1;
                    fin.hit      = 1'b1;
                    fin.value    = rd.value;
                    fin.nxt_slot = iidx_reg + 1'b1;
                end
                else if (iidx_reg == CW'(chm_pkg::SLOTS - 1))
                begin
                    finish       = 1'b1;
                    fin.nxt_slot = CW'(chm_pkg::SLOTS);
                    fin.status   = chm_pkg::ST_END;
                end
                else
                begin
                    iidx_next  = iidx_reg + 1'b1;
                    addr_next  = SW'(iidx_reg + 1'b1);
                    state_next = B_ITRD;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        // Load the result word
        if (finish)
        begin
            res_next       = fin;
            res_next.total = count_next;
            out_valid_next = 1'b1;
            state_next     = B_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        addr_reg  <= addr_next;
        probe_reg <= probe_next;
        nx_reg    <= nx_next;
        shift_reg <= shift_next;
        iidx_reg  <= iidx_next;
        held_reg  <= held_next;
        mov_reg   <= mov_next;
        res_reg   <= res_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(chm_pkg::SLOTS))
        else $error("occupied count beyond table size");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == B_IDLE && !out_valid_reg))
        else $error("queue popped while busy");

    a_iter_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_ITEX || state_reg == B_ITRD) |-> !mem_req.we)
        else $error("table written during scan");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SEX || state_reg == B_REX) |=> $stable(count_reg))
        else $error("count changed during cluster repair");

endmodule
`default_nettype wire

[design/coord_hash_map_linear_probe_unit.sv]
// The front mixes each key in its hash steps, then the back reads the table slot by slot
// (one probe slot, one scanned slot, or one moved entry plus its probe) and loads the result.
// The back takes the next queued word only once it is idle and its last result has been taken.
// A two-word queue lets the front mix the next key while the back walks the table.
// Reset (rst_n, async, active low) clears control state, then a pass over all 1024 slots
// clears every valid mark; words are queued but not executed during that pass.
`default_nettype none
module coord_hash_map_linear_probe_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // key_x[31:0], key_z[63:32], value_handle[95:64], start_slot[106:96], zero fill
    input  wire logic [chm_pkg::S_DATA_W-1:0]  s_tdata,
    // action[1:0]
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // hit[0], value_out[32:1], next_slot[43:33], entry_total[54:44], zero fill
    output logic [chm_pkg::M_DATA_W-1:0]       m_tdata,
    // status[1:0]
    output logic [1:0]                         m_tuser
);

    logic                          q_valid, q_pop;
    chm_pkg::item_t                q_item;
    chm_pkg::mem_req_t             mem_req;
    logic [chm_pkg::ENTRY_W-1:0]   mem_rdata;
    chm_pkg::res_t                 res;

    chm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    chm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    chm_ram #(
        .WIDTH (chm_pkg::ENTRY_W),
        .DEPTH (chm_pkg::SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    // Pack the result word
    assign m_tdata = {1'b0, res.total, res.nxt_slot, res.value, res.hit};
    assign m_tuser = res.status;

endmodule
`default_nettype wire
